// ===== hdl/xrr_pkg.sv =====
// ----------------------------------------------------------------------------
// xrr_pkg
// Shared types and constants for the range random generator.
// ----------------------------------------------------------------------------
package xrr_pkg;

   // Request kinds carried in req_tuser
   typedef enum logic [1:0] {
      KIND_SEED  = 2'd0,
      KIND_FRAC  = 2'd1,
      KIND_RAW   = 2'd2,
      KIND_RANGE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_BOOT,
      ST_IDLE,
      ST_WARM,
      ST_MUL,
      ST_RESULT
   } state_type;

   localparam int WARMUP_STEPS = 16;
   localparam int WARM_CNT_W   = $clog2(WARMUP_STEPS);

   // Controller to datapath
   typedef struct packed {
      logic capture;      // latch request fields
      logic load_seed;    // load seed words into the generator
      logic step;         // advance generator, start output product
      logic mul9;         // finish output product, build mask
      logic load_result;  // write result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type req_kind;
      logic     req_invalid;  // incoming range has low above high
      logic     reject;       // masked draw lies above the span
   } stat_type;

endpackage

// ===== hdl/xrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// xrr_ctrl
// Sequencer: request accept, warm-up count, redraw loop, result handoff.
// ----------------------------------------------------------------------------
module xrr_ctrl import xrr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type             state_ff, state_in;
   logic [WARM_CNT_W-1:0] warm_cnt_ff, warm_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BOOT;
         warm_cnt_ff  <= WARM_CNT_W'(WARMUP_STEPS - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         warm_cnt_ff  <= warm_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state
   always_comb begin
      state_in    = state_ff;
      warm_cnt_in = warm_cnt_ff;
      case (state_ff)
         ST_BOOT: begin
            warm_cnt_in = warm_cnt_ff - 1'b1;
            if (warm_cnt_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (stat.req_kind == KIND_SEED) begin
                  state_in    = ST_WARM;
                  warm_cnt_in = WARM_CNT_W'(WARMUP_STEPS - 1);
               end else if (stat.req_kind == KIND_RANGE && stat.req_invalid) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_WARM: begin
            warm_cnt_in = warm_cnt_ff - 1'b1;
            if (warm_cnt_ff == '0) begin
               state_in = ST_RESULT;
            end
         end
         ST_MUL: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (stat.reject) begin
               state_in = ST_MUL;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_BOOT: begin
            cmd.step = 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (stat.req_kind == KIND_SEED) begin
                  cmd.load_seed = 1'b1;
               end else if (!(stat.req_kind == KIND_RANGE && stat.req_invalid)) begin
                  cmd.step = 1'b1;
               end
            end
         end
         ST_WARM: begin
            cmd.step = 1'b1;
         end
         ST_MUL: begin
            cmd.mul9 = 1'b1;
         end
         ST_RESULT: begin
            if (stat.reject) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               cmd.load_result = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/xrr_dp.sv =====
// ----------------------------------------------------------------------------
// xrr_dp
// Generator state, output scrambler, range fit and result register.
// ----------------------------------------------------------------------------
module xrr_dp import xrr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  kind_type           req_kind,
   input  logic        [63:0] req_seed_a,
   input  logic        [63:0] req_seed_b,
   input  logic signed [63:0] req_range_low,
   input  logic signed [63:0] req_range_high,
   output logic        [63:0] rsp_value,
   output logic               rsp_status
);

   localparam logic [63:0] SEED_WORD1     = 64'hff;
   localparam int          SHIFT_W1       = 17;
   localparam int          ROT_W3         = 45;
   localparam int          ROT_OUT        = 7;
   localparam int          MUL5_SHIFT     = 2;   // x*5 = x + 4x
   localparam int          MUL9_SHIFT     = 3;   // x*9 = x + 8x
   localparam int          FRACTION_SHIFT = 11;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int k);
      return (x << k) | (x >> (64 - k));
   endfunction

   function automatic logic [63:0] fill_mask(input logic [63:0] s);
      logic [63:0] m;
      m = s;
      for (int i = 0; i < 6; i++) begin
         m = m | (m >> (1 << i));
      end
      return m;
   endfunction

   logic [63:0] w0_ff, w1_ff, w2_ff, w3_ff;
   logic [63:0] w0_in, w1_in, w2_in, w3_in;
   logic [63:0] t2, t3;
   logic [63:0] prod_ff;     // w1 * 5
   logic [63:0] draw_ff;     // scrambled output
   logic [63:0] mask_ff;
   logic [63:0] rot_prod;
   logic [63:0] masked;
   kind_type    kind_ff;
   logic [63:0] low_ff;
   logic [63:0] span_ff;
   logic        invalid_ff;
   logic [63:0] value_in;
   logic [63:0] rsp_value_ff;
   logic        rsp_status_ff;

   // Generator step
   always_comb begin
      t2    = w2_ff ^ w0_ff;
      t3    = w3_ff ^ w1_ff;
      w0_in = w0_ff ^ t3;
      w1_in = w1_ff ^ t2;
      w2_in = t2 ^ (w1_ff << SHIFT_W1);
      w3_in = rotl64(t3, ROT_W3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w0_ff <= '0;
         w1_ff <= SEED_WORD1;
         w2_ff <= '0;
         w3_ff <= '0;
      end else if (cmd.load_seed) begin
         w0_ff <= req_seed_a;
         w1_ff <= SEED_WORD1;
         w2_ff <= req_seed_b;
         w3_ff <= '0;
      end else if (cmd.step) begin
         w0_ff <= w0_in;
         w1_ff <= w1_in;
         w2_ff <= w2_in;
         w3_ff <= w3_in;
      end
   end

   assign rot_prod = rotl64(prod_ff, ROT_OUT);
   assign masked   = draw_ff & mask_ff;

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         prod_ff <= w1_ff + (w1_ff << MUL5_SHIFT);
      end
      if (cmd.mul9) begin
         draw_ff <= rot_prod + (rot_prod << MUL9_SHIFT);
         mask_ff <= fill_mask(span_ff);
      end
      if (cmd.capture) begin
         kind_ff    <= req_kind;
         low_ff     <= req_range_low;
         span_ff    <= req_range_high - req_range_low;
         invalid_ff <= (req_range_low > req_range_high);
      end
      if (cmd.load_result) begin
         rsp_value_ff  <= value_in;
         rsp_status_ff <= (kind_ff == KIND_RANGE) && invalid_ff;
      end
   end

   always_comb begin
      case (kind_ff)
         KIND_SEED:  value_in = '0;
         KIND_FRAC:  value_in = draw_ff >> FRACTION_SHIFT;
         KIND_RAW:   value_in = draw_ff;
         KIND_RANGE: value_in = invalid_ff ? 64'd0 : masked + low_ff;
         default:    value_in = '0;
      endcase
   end

   assign stat.req_kind    = req_kind;
   assign stat.req_invalid = (req_range_low > req_range_high);
   assign stat.reject      = (kind_ff == KIND_RANGE) && !invalid_ff && (masked > span_ff);

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== hdl/xoshiro_range_random.sv =====
// ----------------------------------------------------------------------------
// xoshiro_range_random
// xoshiro256** generator serving seed, raw, fraction and range requests.
//
// Each accepted request gets exactly one response. A seed request (tuser 0)
// loads (seed_a, 0xff, seed_b, 0), runs 16 warm-up steps and answers zero.
// A fraction draw (1) returns the top 53 output bits as an unsigned 0.53
// value, a raw draw (2) the full 64-bit output, and a range draw (3) a value
// in the signed inclusive range [range_low, range_high] by mask and redraw;
// if range_low is above range_high it answers zero with status 1 and leaves
// the generator untouched. One request is in work at a time. The output
// scrambler forms w1*5 with one add as the state advances and the
// rotate-and-*9 with a second add in the next cycle; warm-up runs one
// generator step per cycle. After reset the block runs its own 16-step
// warm-up (req_tready low) from all-zero seeds. A finished response waits
// in an output register, so the next request is taken while it is still
// unread.
// ----------------------------------------------------------------------------
module xoshiro_range_random import xrr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,   // seed_a[63:0], seed_b[127:64],
                                     // range_low[191:128], range_high[255:192]
   input  logic [1:0]   req_tuser,   // kind[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // value[63:0]
   output logic [0:0]   rsp_tuser    // status[0]
);

   cmd_type            cmd;
   stat_type           stat;
   logic signed [63:0] range_low;
   logic signed [63:0] range_high;
   logic               rsp_status;

   // Unpack the request fields
   assign range_low  = req_tdata[191:128];
   assign range_high = req_tdata[255:192];

   // Sequencer: accept, warm-up, redraw loop, response handoff
   xrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Generator state, scrambler, range fit and response register
   xrr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (kind_type'(req_tuser)),
      .req_seed_a     (req_tdata[63:0]),
      .req_seed_b     (req_tdata[127:64]),
      .req_range_low  (range_low),
      .req_range_high (range_high),
      .rsp_value      (rsp_tdata),
      .rsp_status     (rsp_status)
   );

   assign rsp_tuser = rsp_status;

   // An invalid-range response always carries a zero value
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("invalid-range response with nonzero value");

   // Only one request in work: no accept in the cycle after an accept
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // No response is raised straight out of reset
   a_boot_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response raised out of reset");

endmodule

// ===== test/xrr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrr_checker
// Watches both streams of the range random generator. It keeps its own copy
// of the xoshiro256** state, predicts the response to every accepted request
// and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module xrr_checker import xrr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [255:0] req_tdata,   // seed_a[63:0], seed_b[127:64],
                                     // range_low[191:128], range_high[255:192]
   input  logic [1:0]   req_tuser,   // kind[1:0]
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [63:0]  rsp_tdata,   // value[63:0]
   input  logic [0:0]   rsp_tuser,   // status[0]
   output int           fail_count,
   output int           pending_count
);

   localparam logic [63:0] SEED_FILL  = 64'hff;
   localparam int          OUT_ROT    = 7;
   localparam int          W3_ROT     = 45;
   localparam int          W1_SHIFT   = 17;
   localparam int          FRAC_SHIFT = 11;
   localparam int          PRINT_MAX  = 100;

   typedef struct {
      logic [63:0] value;
      logic        status;
   } draw_result_type;

   draw_result_type expected_draws[$];
   logic [63:0]     gen_words [4];
   int              mismatches = 0;
   int              rsp_index  = 0;
   int              outstanding = 0;

   assign fail_count    = mismatches;
   assign pending_count = outstanding;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int k);
      return (x << k) | (x >> (64 - k));
   endfunction

   task automatic advance_generator(output logic [63:0] draw);
      logic [63:0] w0, w1, w2, w3;
      w0 = gen_words[0];
      w1 = gen_words[1];
      w2 = gen_words[2] ^ w0;
      w3 = gen_words[3] ^ w1;
      draw = rotl64(w1 * 64'd5, OUT_ROT) * 64'd9;
      gen_words[0] = w0 ^ w3;
      gen_words[1] = w1 ^ w2;
      gen_words[2] = w2 ^ (w1 << W1_SHIFT);
      gen_words[3] = rotl64(w3, W3_ROT);
   endtask

   task automatic seed_generator(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] discard;
      gen_words[0] = a;
      gen_words[1] = SEED_FILL;
      gen_words[2] = b;
      gen_words[3] = 64'd0;
      repeat (WARMUP_STEPS) advance_generator(discard);
   endtask

   // Mask and redraw until the value lies within the span.
   task automatic fit_to_span(input logic [63:0] first, input logic [63:0] span,
                              output logic [63:0] fitted);
      logic [63:0] mask, draw;
      int          sh;
      if ((span & (span + 64'd1)) == 64'd0) begin
         fitted = first & span;
      end else begin
         mask = span;
         for (sh = 1; sh < 64; sh = sh * 2) mask = mask | (mask >> sh);
         fitted = first & mask;
         while (fitted > span) begin
            advance_generator(draw);
            fitted = draw & mask;
         end
      end
   endtask

   task automatic compute_draw(output draw_result_type res);
      kind_type    kind;
      logic [63:0] lo, hi, draw, fitted;
      kind = kind_type'(req_tuser);
      lo   = req_tdata[191:128];
      hi   = req_tdata[255:192];
      res.value  = 64'd0;
      res.status = 1'b0;
      case (kind)
         KIND_SEED: seed_generator(req_tdata[63:0], req_tdata[127:64]);
         KIND_FRAC: begin
            advance_generator(draw);
            res.value = draw >> FRAC_SHIFT;
         end
         KIND_RAW: advance_generator(res.value);
         default: begin
            if ($signed(lo) > $signed(hi)) begin
               res.status = 1'b1;
            end else begin
               advance_generator(draw);
               fit_to_span(draw, hi - lo, fitted);
               res.value = fitted + lo;
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < PRINT_MAX)
         $display("MISMATCH response %0d %s: got %h expected %h",
                  rsp_index, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      draw_result_type want, fresh;
      if (reset) begin
         seed_generator(64'd0, 64'd0);
         expected_draws.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_draws.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata, 64'd0);
            end else begin
               want = expected_draws.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch("value", rsp_tdata, want.value);
               if (rsp_tuser[0] !== want.status)
                  report_mismatch("status", {63'd0, rsp_tuser[0]}, {63'd0, want.status});
            end
            rsp_index++;
         end
         if (req_tvalid && req_tready) begin
            compute_draw(fresh);
            expected_draws.push_back(fresh);
         end
      end
      outstanding <= expected_draws.size();
   end

endmodule

// ===== test/tb_xoshiro_range_random.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_xoshiro_range_random
// Stimulus for the range random generator: a directed set covering the edge
// cases of every request kind, then randomized seed, raw, fraction and range
// requests with random gaps on both streams, one long response stall and one
// drain pause. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_xoshiro_range_random;
   import xrr_pkg::*;

   localparam int          RANDOM_ITEMS = 1150;
   localparam int          PAUSE_AT     = 600;   // drain everything here once
   localparam int          HOLD_AT      = 350;   // response index of long stall
   localparam int          HOLD_CYCLES  = 300;
   localparam int          TAIL_CYCLES  = 40;
   localparam int          MAX_GAP      = 11;
   localparam logic [63:0] S64_MIN      = 64'h8000_0000_0000_0000;
   localparam logic [63:0] S64_MAX      = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL_ONES     = 64'hffff_ffff_ffff_ffff;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [255:0] req_tdata;   // seed_a[63:0], seed_b[127:64],
                              // range_low[191:128], range_high[255:192]
   logic [1:0]   req_tuser;   // kind[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;   // value[63:0]
   logic [0:0]   rsp_tuser;   // status[0]

   int fail_count;
   int pending_count;

   // Set by the response side while it stalls on purpose, so the request
   // side keeps offering back to back and the block backs up.
   logic hold_off = 1'b0;
   int   req_burst = 0;
   int   rsp_burst = 0;

   xoshiro_range_random u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   xrr_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Draw the idle gap: zero inside a burst, otherwise 0 to MAX_GAP, with an
   // occasional back-to-back burst; requests skip it while the far side stalls.
   function automatic int draw_gap(ref int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) burst = $urandom_range(20, 60);
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Offer one request after a random gap and hold it until accepted.
   task automatic issue_request(input kind_type kind, input logic [63:0] seed_a,
                                input logic [63:0] seed_b, input logic [63:0] range_low,
                                input logic [63:0] range_high);
      int gap;
      gap = hold_off ? 0 : draw_gap(req_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {range_high, range_low, seed_b, seed_a};
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Build one random request. Most are draws; range requests mix narrow
   // spans, fully random bounds, spans around powers of two, inverted
   // bounds and single-point ranges.
   task automatic issue_random_request();
      int          pick, sel, k;
      kind_type    kind;
      logic [63:0] lo, hi, span;
      pick = $urandom_range(0, 99);
      lo   = rand64();
      hi   = rand64();
      if (pick < 8) kind = KIND_SEED;
      else if (pick < 26) kind = KIND_FRAC;
      else if (pick < 44) kind = KIND_RAW;
      else kind = KIND_RANGE;
      if (kind == KIND_RANGE) begin
         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            span = 64'($urandom_range(0, 1000));
            hi   = lo + span;
            if ($signed(hi) < $signed(lo)) begin
               hi = lo;
               lo = lo - span;
            end
         end else if (sel < 60) begin
            // keep the raw random bounds; about half come out inverted
         end else if (sel < 85) begin
            k    = $urandom_range(0, 63);
            span = (64'd1 << k) - 64'd1 + 64'($urandom_range(0, 2));
            lo   = -(span >> 1);
            hi   = lo + span;
         end else if (sel < 95) begin
            if ($signed(lo) < $signed(hi)) {lo, hi} = {hi, lo};
         end else begin
            hi = lo;
         end
      end
      issue_request(kind, rand64(), rand64(), lo, hi);
   endtask

   // Response side: random stalls, stall-free bursts and one long hold-off.
   initial begin : response_side
      int rsp_count;
      int wait_cycles;
      rsp_count  = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_count == HOLD_AT) begin
            hold_off   = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off   = 1'b0;
         end
         wait_cycles = draw_gap(rsp_burst);
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_count++;
      end
   end

   // Request side and verdict.
   initial begin : request_side
      int i;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_SEED;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: draws straight from the reset state, then the extremes.
      issue_request(KIND_RAW,   ALL_ONES, ALL_ONES, S64_MAX, S64_MIN);
      issue_request(KIND_FRAC,  64'd0, 64'd0, 64'd0, 64'd0);
      issue_request(KIND_RANGE, 64'd0, 64'd0, S64_MIN, S64_MAX);   // full span
      issue_request(KIND_SEED,  64'd0, 64'd0, ALL_ONES, ALL_ONES);
      issue_request(KIND_RAW,   64'd0, 64'd0, 64'd0, 64'd0);
      issue_request(KIND_SEED,  ALL_ONES, ALL_ONES, 64'd0, 64'd0);
      issue_request(KIND_FRAC,  ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      issue_request(KIND_RANGE, 64'd0, 64'd0, 64'd5, 64'd5);         // zero span
      issue_request(KIND_RANGE, 64'd0, 64'd0, S64_MAX, S64_MIN);   // inverted
      issue_request(KIND_RAW,   64'd0, 64'd0, 64'd0, 64'd0);         // state kept
      issue_request(KIND_RANGE, 64'd0, 64'd0, S64_MIN, 64'd0);     // span 2^63
      issue_request(KIND_RANGE, 64'd0, 64'd0, ALL_ONES, 64'd0);
      issue_request(KIND_RANGE, 64'd0, 64'd0, S64_MAX, S64_MAX);
      issue_request(KIND_RANGE, 64'd0, 64'd0, S64_MIN, S64_MIN);
      issue_request(KIND_RANGE, 64'd0, 64'd0, 64'd0, 64'd5);         // redraws
      issue_request(KIND_RANGE, 64'd0, 64'd0, -64'sd10, 64'd10);
      issue_request(KIND_RANGE, 64'd0, 64'd0, 64'd1, 64'd0);         // off by one
      issue_request(KIND_RANGE, 64'd0, 64'd0, 64'd0, S64_MAX);
      issue_request(KIND_RANGE, 64'd0, 64'd0, ALL_ONES, S64_MAX);
      issue_request(KIND_SEED,  rand64(), rand64(), rand64(), rand64());
      issue_request(KIND_FRAC,  rand64(), rand64(), rand64(), rand64());
      issue_request(KIND_RANGE, 64'd0, 64'd0, 64'd0, 64'h0000_0000_0000_ffff);
      issue_request(KIND_RAW,   rand64(), rand64(), rand64(), rand64());

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == PAUSE_AT) begin
            // Pause until the block has answered everything.
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
         issue_random_request();
      end

      // Drain, then give stray responses a chance to show up.
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
